FILE: hw/rtl/spu_adpcm_pkg.sv
// ----------------------------------------------------------------------------
// SPU ADPCM package
// Shared types, codes and the prediction coefficient table for the voice
// ADPCM block decoder.
// ----------------------------------------------------------------------------
package spu_adpcm_pkg;

  // Transaction kinds carried on in_tuser.
  localparam logic [1:0] MODE_START   = 2'd0;
  localparam logic [1:0] MODE_WORD    = 2'd1;
  localparam logic [1:0] MODE_LOOP_WR = 2'd2;

  // Loop flag bit positions in the header's flag field (header bits [10:8]).
  localparam int FLG_LOOP_END   = 0;
  localparam int FLG_REPEAT     = 1;
  localparam int FLG_LOOP_START = 2;

  localparam logic [3:0] SHIFT_MAX     = 4'd12;
  localparam logic [3:0] SHIFT_INVALID = 4'd9;
  localparam logic [3:0] FILTER_MAX    = 4'd4;

  localparam logic [2:0] WORD_HEADER = 3'd0;
  localparam logic [2:0] WORD_FINAL  = 3'd7;

  // Decoding parameters taken from a block header.
  typedef struct packed {
    logic [3:0] shift;
    logic [2:0] filter;
  } hdr_t;

  typedef struct packed {
    logic signed [7:0] c0;
    logic signed [7:0] c1;
  } coef_t;

  function automatic coef_t coef_lookup(input logic [2:0] filter);
    coef_t c;
    case (filter)
      3'd1:    c = '{c0: 8'sd60,  c1: 8'sd0};
      3'd2:    c = '{c0: 8'sd115, c1: -8'sd52};
      3'd3:    c = '{c0: 8'sd98,  c1: -8'sd55};
      3'd4:    c = '{c0: 8'sd122, c1: -8'sd60};
      default: c = '{c0: 8'sd0,   c1: 8'sd0};
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/spu_adpcm_alu.sv
// ----------------------------------------------------------------------------
// SPU ADPCM sample unit
// Turns one nibble into one PCM sample: scaled nibble plus two-tap
// prediction, clamped to 16 bits. Shared by all four nibbles of a word.
// ----------------------------------------------------------------------------
module spu_adpcm_alu
  import spu_adpcm_pkg::*;
(
  input  logic [3:0]         nibble,
  input  hdr_t               hdr,
  input  logic signed [15:0] hist1,
  input  logic signed [15:0] hist2,
  output logic signed [15:0] sample
);

  coef_t              coef;
  logic signed [15:0] base;
  logic signed [15:0] scaled;
  logic signed [23:0] prod0;
  logic signed [23:0] prod1;
  logic signed [19:0] sum;

  always_comb begin
    coef   = coef_lookup(hdr.filter);
    base   = $signed({nibble, 12'h000});
    scaled = base >>> hdr.shift;
    prod0  = 24'(hist1) * 24'(coef.c0);
    prod1  = 24'(hist2) * 24'(coef.c1);
    // Each product is floored by 64 before the sum, as the hardware does.
    sum    = 20'(scaled) + 20'(prod0 >>> 6) + 20'(prod1 >>> 6);
    if (sum > 20'sd32767) begin
      sample = 16'sh7FFF;
    end else if (sum < -20'sd32768) begin
      sample = -16'sh8000;
    end else begin
      sample = 16'(sum);
    end
  end

endmodule

FILE: hw/rtl/spu_adpcm_block_decoder.sv
// ----------------------------------------------------------------------------
// SPU ADPCM block decoder
// Decodes the 16-byte ADPCM blocks of one voice and follows its loop flags.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions carry a kind on in_tuser: start voice at an address,
//   one 16-bit block word, or a software write of the repeat address.
//   Start, repeat-address writes and header words (the first word of each
//   block) give no output. A data word is accepted into a word register
//   and then decoded in the shared sample unit, one sample per cycle
//   while the receiver does not stall, low nibble first, because each
//   sample feeds the prediction of the next. The next data word is taken
//   only after the fourth sample of the last one has been produced.
//   out_tlast marks the last sample of a block, which also carries the
//   next block address and the loop-jump flag.
//   in_tready is low while a word is being decoded. When the receiver
//   stalls, the sample held in the output register waits and decoding
//   pauses; the next input can be taken while the final sample waits.
//   Synchronous reset clears history, header, addresses and flags and
//   leaves the block idle with no output pending.
// ----------------------------------------------------------------------------
module spu_adpcm_block_decoder
  import spu_adpcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] word, [31:16] address
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] sample, [31:16] next_address,
                                  // [32] loop_jumped, [33] end_seen, zeros above
  output logic        out_tlast   // block_last
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic               state_r, state_nxt;
  logic [1:0]         k_r, k_nxt;
  logic [15:0]        word_r, word_nxt;
  logic signed [15:0] hist1_r, hist1_nxt;
  logic signed [15:0] hist2_r, hist2_nxt;
  hdr_t               hdr_r, hdr_nxt;
  logic [2:0]         flags_r, flags_nxt;
  logic [2:0]         wpos_r, wpos_nxt;
  logic [15:0]        fetch_r, fetch_nxt;
  logic [15:0]        loop_r, loop_nxt;
  logic               keep_r, keep_nxt;
  logic               first_r, first_nxt;
  logic               endf_r, endf_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [39:0]        out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;

  logic               in_acc;
  logic [1:0]         in_mode;
  logic [15:0]        in_word;
  logic [15:0]        in_addr;
  logic               step;
  logic               blk_end;
  logic [3:0]         nibble;
  logic signed [15:0] sample;
  logic [15:0]        loop_upd;
  logic [15:0]        fetch_upd;
  logic               end_upd;

  assign in_mode   = in_tuser;
  assign in_word   = in_tdata[15:0];
  assign in_addr   = in_tdata[31:16];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign step      = (state_r == ST_RUN) && (!out_valid_r || out_tready);
  assign blk_end   = step && (k_r == 2'd3) && (wpos_r == WORD_FINAL);

  always_comb begin
    case (k_r)
      2'd0:    nibble = word_r[3:0];
      2'd1:    nibble = word_r[7:4];
      2'd2:    nibble = word_r[11:8];
      default: nibble = word_r[15:12];
    endcase
  end

  spu_adpcm_alu u_alu (
    .nibble (nibble),
    .hdr    (hdr_r),
    .hist1  (hist1_r),
    .hist2  (hist2_r),
    .sample (sample)
  );

  // Block-end address bookkeeping. A loop end jumps to the loop address
  // as updated by a loop start in the same block.
  always_comb begin
    loop_upd  = (flags_r[FLG_LOOP_START] && (!keep_r || !first_r)) ? fetch_r : loop_r;
    fetch_upd = flags_r[FLG_LOOP_END] ? loop_upd : fetch_r + 16'd1;
    end_upd   = endf_r | flags_r[FLG_LOOP_END] | flags_r[FLG_REPEAT];
  end

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    word_nxt      = word_r;
    hist1_nxt     = hist1_r;
    hist2_nxt     = hist2_r;
    hdr_nxt       = hdr_r;
    flags_nxt     = flags_r;
    wpos_nxt      = wpos_r;
    fetch_nxt     = fetch_r;
    loop_nxt      = loop_r;
    keep_nxt      = keep_r;
    first_nxt     = first_r;
    endf_nxt      = endf_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_acc) begin
      case (in_mode)
        MODE_START: begin
          fetch_nxt = in_addr;
          wpos_nxt  = WORD_HEADER;
          hist1_nxt = '0;
          hist2_nxt = '0;
          first_nxt = 1'b1;
          keep_nxt  = 1'b0;
          endf_nxt  = 1'b0;
        end
        MODE_LOOP_WR: begin
          loop_nxt = in_addr;
          keep_nxt = 1'b1;
        end
        MODE_WORD: begin
          if (wpos_r == WORD_HEADER) begin
            hdr_nxt.shift  = (in_word[3:0] > SHIFT_MAX) ? SHIFT_INVALID : in_word[3:0];
            hdr_nxt.filter = (in_word[7:4] > FILTER_MAX) ? 3'd0 : in_word[6:4];
            flags_nxt      = in_word[10:8];
            wpos_nxt       = 3'd1;
          end else begin
            word_nxt  = in_word;
            k_nxt     = 2'd0;
            state_nxt = ST_RUN;
          end
        end
        default: begin
        end
      endcase
    end

    if (step) begin
      hist2_nxt     = hist1_r;
      hist1_nxt     = sample;
      k_nxt         = k_r + 2'd1;
      out_valid_nxt = 1'b1;
      out_last_nxt  = blk_end;
      if (blk_end) begin
        out_data_nxt = {6'd0, end_upd, flags_r[FLG_LOOP_END], fetch_upd, sample};
      end else begin
        out_data_nxt = {6'd0, endf_r, 1'b0, 16'd0, sample};
      end
      if (k_r == 2'd3) begin
        state_nxt = ST_IDLE;
        if (blk_end) begin
          loop_nxt  = loop_upd;
          fetch_nxt = fetch_upd;
          endf_nxt  = end_upd;
          first_nxt = 1'b0;
          wpos_nxt  = WORD_HEADER;
          if (flags_r[FLG_LOOP_END]) begin
            keep_nxt = 1'b0;
          end
        end else begin
          wpos_nxt = wpos_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      hist1_r     <= '0;
      hist2_r     <= '0;
      hdr_r       <= '0;
      flags_r     <= '0;
      wpos_r      <= WORD_HEADER;
      fetch_r     <= '0;
      loop_r      <= '0;
      keep_r      <= 1'b0;
      first_r     <= 1'b1;
      endf_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      hist1_r     <= hist1_nxt;
      hist2_r     <= hist2_nxt;
      hdr_r       <= hdr_nxt;
      flags_r     <= flags_nxt;
      wpos_r      <= wpos_nxt;
      fetch_r     <= fetch_nxt;
      loop_r      <= loop_nxt;
      keep_r      <= keep_nxt;
      first_r     <= first_nxt;
      endf_r      <= endf_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  // The fourth sample of a word always returns the sequencer to idle.
  a_word_done: assert property (@(posedge clk) disable iff (!rst_n)
    step && (k_r == 2'd3) |=> state_r == ST_IDLE)
    else $error("sequencer did not finish after the fourth sample");

  // Address and jump fields are only populated on the last sample of a block.
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[32:16] == 17'd0)
    else $error("address fields set on a sample that does not end a block");

  // The end flag is sticky until the voice is restarted.
  a_end_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    endf_r && !(in_acc && (in_mode == MODE_START)) |=> endf_r)
    else $error("end flag cleared without a voice start");

  // History only moves when a sample is produced or the voice restarts.
  a_hist_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step && !(in_acc && (in_mode == MODE_START)) |=> $stable(hist1_r) && $stable(hist2_r))
    else $error("sample history changed without a decode step");
`endif

endmodule

FILE: test/spu_adpcm_block_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SPU ADPCM block decoder testbench
// Streams voice starts, repeat-address writes and ADPCM block words into the
// decoder and checks every sample, block end address, loop jump and end flag
// against a behavioral model of the voice kept in a scoreboard.
// ----------------------------------------------------------------------------
module spu_adpcm_block_decoder_tb;
  import spu_adpcm_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int ITEMS        = 250;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 20;

  // Three directed blocks: loop start on the first block, loop start and
  // loop end with an invalid shift and filter 4 on the second, repeat on the third.
  localparam logic [15:0] DIRECTED_WORDS [24] = '{
    16'h0400, 16'h7777, 16'h8888, 16'hFFFF, 16'h0000, 16'h1234, 16'hFEDC, 16'h8F70,
    16'h054F, 16'h7777, 16'h7777, 16'h7777, 16'h8888, 16'h8888, 16'h8888, 16'h0F0F,
    16'hFAFC, 16'h0000, 16'h7777, 16'h8888, 16'h1111, 16'hEEEE, 16'h7F80, 16'h0000
  };

  typedef struct packed {
    logic [15:0] sample;
    logic        block_last;
    logic [15:0] next_address;
    logic        loop_jumped;
    logic        end_seen;
  } sample_exp_t;

  class sample_scoreboard;
    sample_exp_t       expected_samples[$];
    int                errors;
    logic signed [15:0] hist_one, hist_two;
    logic [3:0]        shift_amt;
    logic [2:0]        filter_sel;
    logic [2:0]        flags;
    logic [2:0]        word_pos;
    logic [15:0]       fetch_addr, loop_addr;
    logic              keep_loop, first_blk, end_sticky;

    function new();
      errors     = 0;
      hist_one   = '0;
      hist_two   = '0;
      shift_amt  = '0;
      filter_sel = '0;
      flags      = '0;
      word_pos   = WORD_HEADER;
      fetch_addr = '0;
      loop_addr  = '0;
      keep_loop  = 1'b0;
      first_blk  = 1'b1;
      end_sticky = 1'b0;
    endfunction

    function logic [15:0] predict_sample(logic [3:0] nib);
      int n, acc, c0, c1;
      case (filter_sel)
        3'd1: begin c0 = 60;  c1 = 0;   end
        3'd2: begin c0 = 115; c1 = -52; end
        3'd3: begin c0 = 98;  c1 = -55; end
        3'd4: begin c0 = 122; c1 = -60; end
        default: begin c0 = 0; c1 = 0; end
      endcase
      n = int'($signed(nib));
      acc = (n * 4096) >>> shift_amt;
      acc += (int'(hist_one) * c0) >>> 6;
      acc += (int'(hist_two) * c1) >>> 6;
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      hist_two = hist_one;
      hist_one = acc[15:0];
      return acc[15:0];
    endfunction

    function void note_input(logic [1:0] mode, logic [15:0] word, logic [15:0] addr);
      sample_exp_t e;
      logic        jumped;
      case (mode)
        MODE_START: begin
          fetch_addr = addr;
          word_pos   = WORD_HEADER;
          hist_one   = '0;
          hist_two   = '0;
          first_blk  = 1'b1;
          keep_loop  = 1'b0;
          end_sticky = 1'b0;
        end
        MODE_LOOP_WR: begin
          loop_addr = addr;
          keep_loop = 1'b1;
        end
        MODE_WORD: begin
          if (word_pos == WORD_HEADER) begin
            shift_amt  = (word[3:0] > SHIFT_MAX) ? SHIFT_INVALID : word[3:0];
            filter_sel = (word[7:4] > FILTER_MAX) ? 3'd0 : word[6:4];
            flags      = word[10:8];
            word_pos   = WORD_HEADER + 3'd1;
          end else begin
            for (int k = 0; k < 4; k++) begin
              e = '0;
              e.sample   = predict_sample(word[4*k +: 4]);
              e.end_seen = end_sticky;
              if (k == 3 && word_pos == WORD_FINAL) begin
                jumped = 1'b0;
                if (flags[FLG_LOOP_START] && (!keep_loop || !first_blk))
                  loop_addr = fetch_addr;
                if (flags[FLG_LOOP_END]) begin
                  keep_loop  = 1'b0;
                  fetch_addr = loop_addr;
                  jumped     = 1'b1;
                end else begin
                  fetch_addr = fetch_addr + 16'd1;
                end
                first_blk = 1'b0;
                if (flags[FLG_LOOP_END] || flags[FLG_REPEAT])
                  end_sticky = 1'b1;
                e.block_last   = 1'b1;
                e.next_address = fetch_addr;
                e.loop_jumped  = jumped;
                e.end_seen     = end_sticky;
              end
              expected_samples.push_back(e);
            end
            word_pos = (word_pos == WORD_FINAL) ? WORD_HEADER : word_pos + 3'd1;
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] expv, logic [15:0] actv);
      if (actv !== expv) begin
        $error("%s: expected %h, got %h", name, expv, actv);
        errors++;
      end
    endfunction

    function void check_result(logic [39:0] data, logic last);
      sample_exp_t e;
      if (expected_samples.size() == 0) begin
        $error("unexpected sample %h with no expectation pending", data[15:0]);
        errors++;
        return;
      end
      e = expected_samples.pop_front();
      compare_field("sample", e.sample, data[15:0]);
      compare_field("block_last", 16'(e.block_last), 16'(last));
      compare_field("next_address", e.next_address, data[31:16]);
      compare_field("loop_jumped", 16'(e.loop_jumped), 16'(data[32]));
      compare_field("end_seen", 16'(e.end_seen), 16'(data[33]));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [15:0] word, [31:16] address
  logic [1:0]  in_tuser;   // [1:0] mode
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [15:0] sample, [31:16] next_address, [32] loop_jumped,
                           // [33] end_seen, zeros above
  logic        out_tlast;  // block_last

  sample_scoreboard sb = new();
  int  items_sent    = 0;
  bit  quiet         = 1'b0;
  bit  hold_request  = 1'b0;

  spu_adpcm_block_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_input(in_tuser, in_tdata[15:0], in_tdata[31:16]);
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tlast);
  end

  // Mostly no gap or a short one, now and then a long one; none at all in quiet phases.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] data_word();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 16'h7777;
    if (r == 1) return 16'h8888;
    return 16'($urandom);
  endfunction

  // Offers one transaction, waits for the edge where it is accepted, then may drop in_tvalid for a random gap.
  task automatic send_item(input logic [1:0] mode, input logic [15:0] word,
                           input logic [15:0] addr);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {addr, word};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (mode != MODE_UNUSED) items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off when requested.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle = 0;
      else
        idle++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int          r;
    int          nwords;
    bit          hold_done;
    logic [15:0] hdr;
    hold_done = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= MODE_START;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(MODE_UNUSED, 16'hFFFF, 16'hFFFF);
    send_item(MODE_START, 16'h0000, 16'hFFFF);
    send_item(MODE_LOOP_WR, 16'hFFFF, 16'h8000);
    foreach (DIRECTED_WORDS[i])
      send_item(MODE_WORD, DIRECTED_WORDS[i], 16'h0000);

    send_item(MODE_START, 16'($urandom), 16'($urandom));
    while (items_sent < ITEMS) begin
      quiet = ((items_sent / 60) % 3 == 2);
      if (!hold_done && items_sent >= 120) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_item(MODE_UNUSED, 16'($urandom), 16'($urandom));
      end else if (r < 12) begin
        send_item(MODE_LOOP_WR, 16'($urandom), 16'($urandom));
      end else if (r < 20) begin
        send_item(MODE_START, 16'($urandom),
                  ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom));
      end else begin
        // Mostly whole blocks; now and then one is cut short.
        nwords = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 6) : 7;
        hdr = 16'($urandom);
        if ($urandom_range(0, 1) == 1) hdr[3:0] = 4'($urandom_range(0, 3));
        send_item(MODE_WORD, hdr, 16'($urandom));
        repeat (nwords) begin
          if ($urandom_range(0, 40) == 0)
            send_item(MODE_LOOP_WR, 16'($urandom), 16'($urandom));
          send_item(MODE_WORD, data_word(), 16'($urandom));
        end
      end
    end
    in_tvalid <= 1'b0;
    quiet = 1'b0;

    while (sb.expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: spu_adpcm_block_decoder.f
hw/rtl/spu_adpcm_pkg.sv
hw/rtl/spu_adpcm_alu.sv
hw/rtl/spu_adpcm_block_decoder.sv
test/spu_adpcm_block_decoder_tb.sv
